>>> sv/mtg_pkg.sv
// Shared constants, state type and word functions for the MT19937 generator.
package mtg_pkg;

  localparam int unsigned ADDR_W = 10;

  localparam logic [ADDR_W-1:0] N_WORDS   = 10'd624;
  localparam logic [ADDR_W-1:0] LAST_ADDR = 10'd623;
  localparam logic [ADDR_W-1:0] TWIST_OFS = 10'd397;

  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC60000;
  localparam logic [31:0] UPPER_MASK   = 32'h80000000;
  localparam logic [31:0] LOWER_MASK   = 32'h7FFFFFFF;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TWIST_FIRST,
    ST_TWIST,
    ST_DRAW
  } mtg_state_t;

  // address step with wrap at the end of the state array
  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  // init recurrence: low 32 bits of MULT * (p ^ p>>30) + k
  function automatic logic [31:0] seed_word(input logic [31:0] prev,
                                            input logic [ADDR_W-1:0] k);
    return INIT_MULT * (prev ^ (prev >> 30)) + {22'd0, k};
  endfunction

  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] ya;
    y  = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    ya = (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    return far ^ ya;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> sv/mersenne_twister_generator.sv
// Top level of the MT19937 generator: state memory, sequencer and tempering.
//
// Usage: present req_type and seed_value with start high while busy is low;
// that edge takes the beat. req_type 0 reseeds, req_type 1 draws one word.
// A draw result shows on random_word for exactly one cycle with done high;
// the receiver cannot hold it off, and none is needed, since results leave
// from an output register that is free again by the next draw.
//
// Request flow:
//   reseed  : busy while seeding (seed word on the accepting edge, then one
//             init step per cycle, each one 32x32 multiply on the word
//             written the cycle before).
//   draw    : busy through ST_DRAW; done rises in the same cycle as busy drops.
//   draw on an exhausted state: busy through the twist and then the draw;
//             the twist streams through the state memory at one word per cycle
//             (two read ports, one write port), after ST_TWIST_FIRST takes in word 0.
//   draw before any reseed: done comes right after the accepting edge,
//             with a zero word; busy stays low.
//
// Reset (rst, synchronous): control, word index and the seeded mark clear;
// the 624-word memory is left as is and its contents are only used after a reseed.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] seed_value,
  output logic [31:0] random_word,
  output logic        done
);
  import mtg_pkg::*;

  // state memory: two registered read ports, one write port
  logic [31:0] mem [0:623];
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic [31:0] rd_a, rd_b, wr_data;
  logic wr_en;

  mtg_state_t state, state_next;

  logic [ADDR_W-1:0] word_index;  // 0..624, 624 means exhausted
  logic              seeded;
  logic [ADDR_W-1:0] k;           // seed / twist position
  logic [ADDR_W-1:0] pa, pb;      // next twist read addresses
  logic [31:0]       prev;        // last seeded word
  logic [31:0]       cur;         // old mt[k] during twist
  logic [31:0]       seed_nxt;

  logic take;
  assign take = start && (state == ST_IDLE);
  assign busy = (state != ST_IDLE);

  assign seed_nxt = seed_word(prev, k);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (req_type == REQ_SEED) begin
            state_next = ST_SEED;
          end else if (seeded) begin
            state_next = (word_index == N_WORDS) ? ST_TWIST_FIRST : ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        if (k == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_TWIST_FIRST: state_next = ST_TWIST;
      ST_TWIST: begin
        if (k == LAST_ADDR) state_next = ST_DRAW;
      end
      ST_DRAW: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_a_addr = pa;
    rd_b_addr = pb;
    wr_en     = 1'b0;
    wr_addr   = k;
    wr_data   = seed_nxt;
    case (state)
      ST_IDLE: begin
        // word 0 for a twist, else the word to temper
        rd_a_addr = (word_index == N_WORDS) ? '0 : word_index;
        if (take && req_type == REQ_SEED) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = seed_value;
        end
      end
      ST_SEED: begin
        wr_en = 1'b1;
      end
      ST_TWIST_FIRST: begin
        rd_a_addr = 10'd1;
        rd_b_addr = TWIST_OFS;
      end
      ST_TWIST: begin
        wr_en   = 1'b1;
        wr_data = twist_word(cur, rd_a, rd_b);
        // last step fetches word 0 for the draw that follows
        if (k == LAST_ADDR) rd_a_addr = '0;
      end
      ST_DRAW: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a <= mem[rd_a_addr];
    rd_b <= mem[rd_b_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      word_index <= '0;
      seeded     <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take && req_type == REQ_DRAW && !seeded) done <= 1'b1;
        end
        ST_SEED: begin
          if (k == LAST_ADDR) begin
            word_index <= N_WORDS;
            seeded     <= 1'b1;
          end
        end
        ST_TWIST: begin
          if (k == LAST_ADDR) word_index <= '0;
        end
        ST_DRAW: begin
          done       <= 1'b1;
          word_index <= word_index + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        prev        <= seed_value;
        k           <= 10'd1;
        random_word <= 32'd0;
      end
      ST_SEED: begin
        prev <= seed_nxt;
        k    <= k + 1'b1;
      end
      ST_TWIST_FIRST: begin
        cur <= rd_a;
        k   <= '0;
        pa  <= 10'd2;
        pb  <= TWIST_OFS + 1'b1;
      end
      ST_TWIST: begin
        cur <= rd_a;
        k   <= k + 1'b1;
        pa  <= wrap_inc(pa);
        pb  <= wrap_inc(pb);
      end
      ST_DRAW: begin
        random_word <= temper(rd_a);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> test/mersenne_twister_generator_tb.sv
// Self-checking testbench for the MT19937 word generator: directed and random beats.
`timescale 1ns / 100ps

module mersenne_twister_generator_tb;
  import mtg_pkg::*;

  // Golden-side constants, kept apart from the package so a wrong constant
  // there cannot hide itself.
  localparam int          MT_N        = 624;
  localparam int          MT_M        = 397;
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR   = 32'h9908_B0DF;
  localparam logic [31:0] TMASK_B     = 32'h9D2C_5680;
  localparam logic [31:0] TMASK_C     = 32'hEFC6_0000;
  localparam int          RANDOM_BEATS = 480;
  // A reseed keeps the block busy through the seeding pass, a draw on a used-up
  // state through the twist; add the longest sender gap, take it several times over.
  localparam int          STALL_LIMIT = 4000;
  localparam int          MAX_PRINTS  = 40;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [31:0] seed_value;
  logic [31:0] random_word;
  logic        done;

  mersenne_twister_generator u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .seed_value  (seed_value),
    .random_word (random_word),
    .done        (done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Golden generator state: its own copy of the 624-word array, the read
  // index and the seeded mark, advanced once per accepted beat.
  // ---------------------------------------------------------------------
  logic [31:0] gold_mt [0:MT_N-1];
  int          gold_idx;
  bit          gold_seeded;

  logic [31:0] expected_words[$];   // draws accepted but not yet seen on done

  int  err_count;
  int  seeds_sent;
  int  draws_sent;
  int  words_checked;
  int  twists_seen;
  int  idle_max;                    // sender gap bound; 0 gives back-to-back beats

  function automatic logic [31:0] tempered(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TMASK_B);
    y = y ^ ((y << 15) & TMASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void gold_reseed(input logic [31:0] s);
    logic [31:0] p;
    gold_mt[0] = s;
    for (int k = 1; k < MT_N; k++) begin
      p = gold_mt[k-1];
      gold_mt[k] = SEED_MULT * (p ^ (p >> 30)) + 32'(k);
    end
    gold_idx    = MT_N;           // used up: next draw twists first
    gold_seeded = 1'b1;
  endfunction

  function automatic void gold_twist();
    logic [31:0] y;
    logic [31:0] ya;
    for (int k = 0; k < MT_N; k++) begin
      y  = (gold_mt[k] & 32'h8000_0000) | (gold_mt[(k + 1) % MT_N] & 32'h7FFF_FFFF);
      ya = y >> 1;
      if (y[0]) ya = ya ^ TWIST_XOR;
      gold_mt[k] = gold_mt[(k + MT_M) % MT_N] ^ ya;
    end
    gold_idx = 0;
    twists_seen++;
  endfunction

  // Advance the golden state by one accepted beat; a draw queues its word.
  function automatic void predict_beat(input logic rt, input logic [31:0] s);
    if (rt == REQ_SEED) begin
      gold_reseed(s);
      seeds_sent++;
    end else begin
      draws_sent++;
      if (!gold_seeded) begin
        // unseeded draw gives zero and leaves the state alone
        expected_words.push_back(32'd0);
      end else begin
        if (gold_idx >= MT_N) gold_twist();
        expected_words.push_back(tempered(gold_mt[gold_idx]));
        gold_idx++;
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Result checker. done marks a one-cycle result; compare it against the
  // oldest queued draw.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected random_word", random_word, 32'd0);
      end else begin
        if (random_word !== expected_words[0])
          flag_mismatch("random_word", random_word, expected_words[0]);
        void'(expected_words.pop_front());
        words_checked++;
      end
    end
  end

  // Watchdog: cycles with neither an input beat nor a result.
  int stall_cycles;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat or result for %0d cycles", STALL_LIMIT);
        $display("mersenne_twister_generator_tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender. Called right after the previous beat was taken (or after a
  // drain/reset, with start already low). Inputs move only on falling
  // edges, and start gets at most one assignment per edge, so a gap-free
  // follow-on beat keeps start high without a glitch.
  // ---------------------------------------------------------------------
  task automatic send_beat(input logic rt, input logic [31:0] s);
    int gap;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    req_type   <= rt;
    seed_value <= s;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_beat(rt, s);
  endtask

  // Drop start and hold off until every queued result is back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // draws carry a random seed_value so its bits toggle on ignored beats too
  task automatic draw_words(input int count);
    for (int i = 0; i < count; i++) send_beat(REQ_DRAW, $urandom());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Draws before any reseed must return zero and not disturb anything.
  task automatic test_unseeded_draws();
    idle_max = 0;
    send_beat(REQ_DRAW, 32'hFFFF_FFFF);
    send_beat(REQ_DRAW, 32'h0000_0000);
    idle_max = 7;
    send_beat(REQ_DRAW, $urandom());
  endtask

  // Seed extremes, the customary default seed and the top bit alone.
  task automatic test_seed_extremes();
    idle_max = 7;
    send_beat(REQ_SEED, 32'h0000_0000);
    draw_words(3);
    idle_max = 0;
    send_beat(REQ_SEED, 32'hFFFF_FFFF);
    draw_words(3);
    send_beat(REQ_SEED, 32'd5489);
    draw_words(2);
    idle_max = 3;
    send_beat(REQ_SEED, 32'h8000_0000);
    draw_words(1);
  endtask

  // Reseed right after a reseed, and reseed in the middle of a stream.
  task automatic test_reseed_mid_stream();
    idle_max = 0;
    send_beat(REQ_SEED, 32'h1234_5678);
    send_beat(REQ_SEED, 32'h0000_0001);
    draw_words(2);
    send_beat(REQ_SEED, 32'h7FFF_FFFF);
    draw_words(1);
    drain_results();
  endtask

  // Mostly seed-then-draw streams with random length and pacing, with some
  // shuffled seed/draw noise and occasional full drains in between.
  task automatic test_random_streams();
    int left;
    int run;
    left = RANDOM_BEATS;
    while (left > 0) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      if ($urandom_range(0, 7) == 0) begin
        run = $urandom_range(1, 6);
        for (int i = 0; i < run; i++)
          send_beat(($urandom_range(0, 3) == 0) ? REQ_SEED : REQ_DRAW, $urandom());
      end else begin
        run = $urandom_range(1, 40);
        send_beat(REQ_SEED, $urandom());
        draw_words(run);
        run++;
      end
      left -= run;
      if ($urandom_range(0, 5) == 0) drain_results();
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_SEED;
    seed_value   = 32'd0;
    err_count    = 0;
    seeds_sent   = 0;
    draws_sent   = 0;
    words_checked = 0;
    twists_seen  = 0;
    idle_max     = 0;
    gold_idx     = 0;
    gold_seeded  = 1'b0;
    for (int k = 0; k < MT_N; k++) gold_mt[k] = 32'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unseeded_draws();
    test_seed_extremes();
    test_reseed_mid_stream();
    test_random_streams();

    // wind down: all words back, block idle, then a short settle for strays
    drain_results();
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d reseeds and %0d draws, %0d words checked",
             seeds_sent, draws_sent, words_checked);
    $display("state regenerated %0d times under mixed pacing and drains",
             twists_seen);
    if (err_count == 0) begin
      $display("mersenne_twister_generator_tb: clean");
    end else begin
      $display("mersenne_twister_generator_tb: errors");
    end
    $finish;
  end

endmodule
